@@ hw/rtl/modexp_pkg.sv @@
`default_nettype none
package modexp_pkg;

  // field widths of one transaction
  localparam int BASE_W = 64;
  localparam int EXP_W  = 63;
  localparam int MOD_W  = 63;
  localparam int POW_W  = 63;
  // datapath is one bit wider than the modulus so sums never wrap
  localparam int DATA_W = MOD_W + 1;

  localparam int IN_TDATA_W  = ((BASE_W + EXP_W + MOD_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((POW_W + 7) / 8) * 8;

  localparam int ME_WORD_BITS = 64;
  // restoring division of the base magnitude, one quotient bit per cycle
  localparam int DIV_STEPS = BASE_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ME_IDLE,
    ME_REDUCE,
    ME_LIFT,
    ME_LOAD,
    ME_STEP,
    ME_DONE
  } me_state_t;

  // conditional subtraction after an add or a double
  function automatic logic [DATA_W-1:0] csub(input logic [DATA_W-1:0] v,
                                             input logic [MOD_W-1:0] m);
    logic [DATA_W-1:0] mx;
    mx = {1'b0, m};
    return (v >= mx) ? (v - mx) : v;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/modular_exponentiation_top.sv @@
// flow: the base magnitude is reduced mod the modulus and lifted for a negative base, then
//   each exponent bit runs the add-and-double loop; a modulus of 0 or 1 gives result 0
// one transaction at a time: the next one is accepted as soon as the result sits in the
//   output register; multiply and square run together in the shared add-and-double
//   loop, which steps over the bits of the multiplier b, after the base reduction
// reset: rst_n synchronous active low, returns to idle and drops out_tvalid
`default_nettype none
module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int WORD_BITS = ME_WORD_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // base_value, exponent, modulus
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // power_mod
);

  localparam int EB_W = $clog2(WORD_BITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WORD_BITS - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_STEPS - 1);
  localparam logic [EB_W-1:0]   EBIT_LAST = EB_W'(WORD_BITS - 1);

  me_state_t state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [POW_W-1:0]  out_data_r, out_data_nxt;
  logic [MOD_W-1:0]  m_r, m_nxt;
  logic [EXP_W-1:0]  e_r, e_nxt;
  logic              neg_r, neg_nxt;
  logic [BASE_W-1:0] dsh_r, dsh_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [DATA_W-1:0] x1_r, x1_nxt, p1_r, p1_nxt;
  logic [DATA_W-1:0] x2_r, x2_nxt, p2_r, p2_nxt;
  logic [DATA_W-1:0] y_r, y_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [EB_W-1:0]   ebit_r, ebit_nxt;

  logic [BASE_W-1:0] in_base;
  logic [EXP_W-1:0]  in_exp;
  logic [MOD_W-1:0]  in_mod;
  logic [DATA_W-1:0] p1_upd, p2_upd, rem_shift;

  assign in_base = in_tdata[BASE_W-1:0];
  assign in_exp  = in_tdata[BASE_W+EXP_W-1:BASE_W];
  assign in_mod  = in_tdata[BASE_W+EXP_W+MOD_W-1:BASE_W+EXP_W];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-POW_W){1'b0}}, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ME_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    neg_r      <= neg_nxt;
    dsh_r      <= dsh_nxt;
    acc_r      <= acc_nxt;
    b_r        <= b_nxt;
    x1_r       <= x1_nxt;
    p1_r       <= p1_nxt;
    x2_r       <= x2_nxt;
    p2_r       <= p2_nxt;
    y_r        <= y_nxt;
    step_r     <= step_nxt;
    ebit_r     <= ebit_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    neg_nxt       = neg_r;
    dsh_nxt       = dsh_r;
    acc_nxt       = acc_r;
    b_nxt         = b_r;
    x1_nxt        = x1_r;
    p1_nxt        = p1_r;
    x2_nxt        = x2_r;
    p2_nxt        = p2_r;
    y_nxt         = y_r;
    step_nxt      = step_r;
    ebit_nxt      = ebit_r;
    in_tready     = 1'b0;
    rem_shift     = {b_r[DATA_W-2:0], dsh_r[BASE_W-1]};
    p1_upd        = y_r[0] ? csub(p1_r + x1_r, m_r) : p1_r;
    p2_upd        = y_r[0] ? csub(p2_r + x2_r, m_r) : p2_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ME_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          neg_nxt  = in_base[BASE_W-1];
          dsh_nxt  = in_base[BASE_W-1] ? (~in_base + BASE_W'(1)) : in_base;
          e_nxt    = in_exp;
          m_nxt    = in_mod;
          b_nxt    = '0;
          step_nxt = '0;
          if (in_mod <= MOD_W'(1)) begin
            acc_nxt   = '0;
            state_nxt = ME_DONE;
          end else begin
            acc_nxt   = DATA_W'(1);
            state_nxt = ME_REDUCE;
          end
        end
      end
      ME_REDUCE: begin
        // base magnitude mod m, remainder kept in b
        b_nxt    = csub(rem_shift, m_r);
        dsh_nxt  = {dsh_r[BASE_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ME_LIFT;
        end
      end
      ME_LIFT: begin
        if (neg_r && (b_r != '0)) begin
          b_nxt = {1'b0, m_r} - b_r;
        end
        ebit_nxt  = '0;
        state_nxt = ME_LOAD;
      end
      ME_LOAD: begin
        // multiply and square share the multiplier b
        x1_nxt    = acc_r;
        p1_nxt    = '0;
        x2_nxt    = b_r;
        p2_nxt    = '0;
        y_nxt     = b_r;
        step_nxt  = '0;
        state_nxt = ME_STEP;
      end
      ME_STEP: begin
        p1_nxt   = p1_upd;
        p2_nxt   = p2_upd;
        x1_nxt   = csub({x1_r[DATA_W-2:0], 1'b0}, m_r);
        x2_nxt   = csub({x2_r[DATA_W-2:0], 1'b0}, m_r);
        y_nxt    = {1'b0, y_r[DATA_W-1:1]};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_LAST) begin
          step_nxt = '0;
          if (e_r[0]) begin
            acc_nxt = p1_upd;
          end
          b_nxt    = p2_upd;
          e_nxt    = {1'b0, e_r[EXP_W-1:1]};
          ebit_nxt = ebit_r + EB_W'(1);
          state_nxt = (ebit_r == EBIT_LAST) ? ME_DONE : ME_LOAD;
        end
      end
      ME_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = acc_r[POW_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = ME_IDLE;
        end
      end
      default: begin
        state_nxt = ME_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ME_IDLE))
    else $error("accepted transaction did not start work");

  a_operands_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ME_STEP) |-> ((acc_r < {1'b0, m_r}) && (b_r < {1'b0, m_r})))
    else $error("operand not reduced below modulus");

  a_partials_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ME_STEP) |-> ((p1_r < {1'b0, m_r}) && (p2_r < {1'b0, m_r})
                              && (x1_r < {1'b0, m_r}) && (x2_r < {1'b0, m_r})))
    else $error("partial product not reduced below modulus");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ME_DONE && out_valid_r && !out_tready) |=> (state_r == ME_DONE))
    else $error("result overwrote a pending output");

endmodule
`default_nettype wire
